>>> rtl/dlc_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and anchor tables for the dipole localization cost core
// no dependencies

package dlc_pkg;

  localparam int ANCHOR_CNT = 4;

  localparam int POS_W     = 22;
  localparam int ABS_W     = 22;
  localparam int SQR_W     = 2 * ABS_W;
  localparam int VOLT_W    = 32;
  localparam int COST_W    = 64;
  localparam int FREQ_W    = 18;
  localparam int CFG_IDX_W = 8;

  localparam int D2_W      = SQR_W + 2;
  localparam int NUM_W     = SQR_W + 1;
  localparam int Q_W       = 34;
  localparam int S_W       = 32;
  localparam int RAD_SHIFT = 18;
  localparam int RAD_W     = D2_W + RAD_SHIFT;
  localparam int SR_W      = S_W + 2;

  localparam int GAIN_W    = 51;
  localparam int FQ_W      = 52;
  localparam int FQ_SPLIT  = 26;
  localparam int GP_W      = GAIN_W + FQ_SPLIT;
  localparam int NUMV_W    = GAIN_W + FQ_W;
  localparam int D2_SPLIT  = 32;
  localparam int DSL_W     = D2_SPLIT + S_W;
  localparam int DSH_W     = D2_W - D2_SPLIT + S_W;
  localparam int DEN_W     = D2_W + S_W;
  localparam int V_W       = 64;
  localparam int VHI_W     = NUMV_W - V_W;

  localparam logic [GAIN_W-1:0] DIPOLE_GAIN = 51'd1526559361000000;

  localparam logic signed [POS_W-1:0] ANCHOR_XYZ [12] = '{
    -22'sd524288, -22'sd262144, 22'sd0,
     22'sd524288, -22'sd262144, 22'sd0,
     22'sd524288,  22'sd262144, 22'sd0,
    -22'sd524288,  22'sd262144, 22'sd0
  };

  localparam logic [FREQ_W-1:0] ANCHOR_FREQ [4] = '{
    18'd213000, 18'd203000, 18'd193000, 18'd183000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAS_V0 = 8'd0,
    REG_MEAS_V1 = 8'd1,
    REG_MEAS_V2 = 8'd2,
    REG_MEAS_V3 = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic bad;
  } ctl_t;

  function automatic logic [ABS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic [POS_W:0] m;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    m = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
    return m[ABS_W-1:0];
  endfunction

endpackage

>>> rtl/dlc_if.sv
`timescale 1ns / 1ps
// channel interfaces: candidate positions, cost results, register writes
// depends on dlc_pkg

interface dlc_in_if import dlc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface dlc_out_if import dlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost_value;
  logic              saturated;
  modport source (output valid, cost_value, saturated, input ready);
  modport sink   (input valid, cost_value, saturated, output ready);
endinterface

interface dlc_cfg_if import dlc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VOLT_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/dlc_geom.sv
`timescale 1ns / 1ps
// pipelined Q32 ratio divider and distance square root, one bit per stage
// depends on dlc_pkg

module dlc_geom import dlc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  ctl_t             ctl_i,
  input  logic [D2_W-1:0]  d2_i,
  input  logic [NUM_W-1:0] num_i,
  output ctl_t             ctl_o,
  output logic [D2_W-1:0]  d2_o,
  output logic [Q_W-1:0]   q_o,
  output logic [S_W-1:0]   s_o
);

  localparam int STAGES = Q_W;

  ctl_t             ctl_r [STAGES];
  logic [D2_W-1:0]  d2_r  [STAGES];
  logic [D2_W-1:0]  rm_r  [STAGES];
  logic [Q_W-1:0]   qt_r  [STAGES];
  logic [1:0]       nb_r  [STAGES];
  logic [SR_W-1:0]  sr_r  [STAGES];
  logic [S_W-1:0]   rt_r  [STAGES];
  logic [RAD_W-1:0] rad_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    ctl_t             c_in;
    logic [D2_W-1:0]  d2_in, rm_in, rm_nxt;
    logic [Q_W-1:0]   qt_in, qt_nxt;
    logic [1:0]       nb_in;
    logic [SR_W-1:0]  sr_in, sr_nxt;
    logic [S_W-1:0]   rt_in, rt_nxt;
    logic [RAD_W-1:0] rad_in, rad_nxt;
    logic             nbit, dge;
    logic [D2_W:0]    dt;

    if (i == 0) begin : g_first
      assign c_in   = ctl_i;
      assign d2_in  = d2_i;
      assign rm_in  = D2_W'(num_i >> 2);
      assign qt_in  = '0;
      assign nb_in  = num_i[1:0];
      assign sr_in  = '0;
      assign rt_in  = '0;
      assign rad_in = {d2_i, {RAD_SHIFT{1'b0}}};
    end else begin : g_next
      assign c_in   = ctl_r[i-1];
      assign d2_in  = d2_r[i-1];
      assign rm_in  = rm_r[i-1];
      assign qt_in  = qt_r[i-1];
      assign nb_in  = nb_r[i-1];
      assign sr_in  = sr_r[i-1];
      assign rt_in  = rt_r[i-1];
      assign rad_in = rad_r[i-1];
    end

    assign nbit   = (i == 0) ? nb_in[1] : ((i == 1) ? nb_in[0] : 1'b0);
    assign dt     = {rm_in, nbit};
    assign dge    = dt >= {1'b0, d2_in};
    assign rm_nxt = D2_W'(dge ? dt - {1'b0, d2_in} : dt);
    assign qt_nxt = {qt_in[Q_W-2:0], dge};

    if (i < S_W) begin : g_sqrt
      logic [SR_W+1:0] st, trial;
      logic            sge;
      assign st      = {sr_in, rad_in[RAD_W-1 -: 2]};
      assign trial   = (SR_W+2)'({rt_in, 2'b01});
      assign sge     = st >= trial;
      assign sr_nxt  = SR_W'(sge ? st - trial : st);
      assign rt_nxt  = {rt_in[S_W-2:0], sge};
      assign rad_nxt = {rad_in[RAD_W-3:0], 2'b00};
    end else begin : g_hold
      assign sr_nxt  = sr_in;
      assign rt_nxt  = rt_in;
      assign rad_nxt = rad_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2_r[i]  <= d2_in;
        rm_r[i]  <= rm_nxt;
        qt_r[i]  <= qt_nxt;
        nb_r[i]  <= nb_in;
        sr_r[i]  <= sr_nxt;
        rt_r[i]  <= rt_nxt;
        rad_r[i] <= rad_nxt;
      end
    end
  end

  assign ctl_o = ctl_r[STAGES-1];
  assign d2_o  = d2_r[STAGES-1];
  assign q_o   = qt_r[STAGES-1];
  assign s_o   = rt_r[STAGES-1];

endmodule

>>> rtl/dlc_vdiv.sv
`timescale 1ns / 1ps
// pipelined voltage divider with overflow detect, one quotient bit per stage
// depends on dlc_pkg

module dlc_vdiv import dlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ctl_t              ctl_i,
  input  logic [NUMV_W-1:0] num_i,
  input  logic [DEN_W-1:0]  den_i,
  output ctl_t              ctl_o,
  output logic [V_W-1:0]    v_o
);

  localparam int STAGES = V_W;

  ctl_t             ctl0_r;
  logic [DEN_W-1:0] r0_r, den0_r;
  logic [V_W-1:0]   nlo0_r;
  logic             ovf;

  ctl_t             ctl_r [STAGES];
  logic [DEN_W-1:0] r_r   [STAGES];
  logic [DEN_W-1:0] den_r [STAGES];
  logic [V_W-1:0]   nlo_r [STAGES];
  logic [V_W-1:0]   q_r   [STAGES];

  // quotient reaches 2^64 when the high numerator part is at least the divisor
  assign ovf = (den_i[DEN_W-1:VHI_W] == '0) && (num_i[NUMV_W-1:V_W] >= den_i[VHI_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r <= '{valid: ctl_i.valid, bad: ctl_i.bad | ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r   <= DEN_W'(num_i[NUMV_W-1:V_W]);
      den0_r <= den_i;
      nlo0_r <= num_i[V_W-1:0];
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    ctl_t             c_in;
    logic [DEN_W-1:0] r_in, den_in, r_nxt;
    logic [V_W-1:0]   nlo_in, q_in;
    logic [DEN_W:0]   dt;
    logic             ge;

    if (i == 0) begin : g_first
      assign c_in   = ctl0_r;
      assign r_in   = r0_r;
      assign den_in = den0_r;
      assign nlo_in = nlo0_r;
      assign q_in   = '0;
    end else begin : g_next
      assign c_in   = ctl_r[i-1];
      assign r_in   = r_r[i-1];
      assign den_in = den_r[i-1];
      assign nlo_in = nlo_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign dt    = {r_in, nlo_in[V_W-1]};
    assign ge    = dt >= {1'b0, den_in};
    assign r_nxt = DEN_W'(ge ? dt - {1'b0, den_in} : dt);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]   <= r_nxt;
        den_r[i] <= den_in;
        nlo_r[i] <= {nlo_in[V_W-2:0], 1'b0};
        q_r[i]   <= {q_in[V_W-2:0], ge};
      end
    end
  end

  assign ctl_o = ctl_r[STAGES-1];
  assign v_o   = q_r[STAGES-1];

endmodule

>>> rtl/dlc_accum.sv
`timescale 1ns / 1ps
// staged sum of the per-anchor squared errors with overflow flag, one anchor per stage
// depends on dlc_pkg

module dlc_accum import dlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic              bad_i [ANCHOR_CNT],
  input  logic [COST_W-1:0] sq_i  [ANCHOR_CNT],
  output ctl_t              ctl_o,
  output logic [COST_W-1:0] sum_o
);

  ctl_t              ctl_r [ANCHOR_CNT];
  logic [COST_W-1:0] acc_r [ANCHOR_CNT];
  logic              bd_r  [ANCHOR_CNT][ANCHOR_CNT];
  logic [COST_W-1:0] sq_r  [ANCHOR_CNT][ANCHOR_CNT];

  for (genvar j = 0; j < ANCHOR_CNT; j++) begin : g_st
    ctl_t              c_in;
    logic [COST_W-1:0] acc_in;
    logic              bd_in [ANCHOR_CNT];
    logic [COST_W-1:0] sq_in [ANCHOR_CNT];
    logic [COST_W:0]   sum;

    if (j == 0) begin : g_first
      assign c_in   = '{valid: valid_i, bad: 1'b0};
      assign acc_in = '0;
      assign bd_in  = bad_i;
      assign sq_in  = sq_i;
    end else begin : g_next
      assign c_in   = ctl_r[j-1];
      assign acc_in = acc_r[j-1];
      assign bd_in  = bd_r[j-1];
      assign sq_in  = sq_r[j-1];
    end

    assign sum = {1'b0, acc_in} + {1'b0, sq_in[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else if (en) begin
        ctl_r[j] <= '{valid: c_in.valid, bad: c_in.bad | sum[COST_W] | bd_in[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[j] <= sum[COST_W-1:0];
        bd_r[j]  <= bd_in;
        sq_r[j]  <= sq_in;
      end
    end
  end

  assign ctl_o = ctl_r[ANCHOR_CNT-1];
  assign sum_o = acc_r[ANCHOR_CNT-1];

endmodule

>>> rtl/dipole_localization_cost_core.sv
`timescale 1ns / 1ps
// dipole localization cost core: per-anchor field model and error sum
// depends on dlc_pkg, dlc_if, dlc_geom, dlc_vdiv, dlc_accum
//
// in_ch carries a candidate position (pos_x, pos_y, pos_z, 2^-20 m); out_ch
// returns cost_value (2^-80 V^2) and saturated. cfg_ch writes measured_v0..3
// by index; indexes above 3 are dropped and cfg_ch.ready is always high.
// Writes are meant for an idle block.
// One position is accepted every cycle while out_ch does not stall. Each
// result passes 3 front-end stages, 34 stages of ratio divider and square
// root, 3 multiply stages, 65 stages of voltage divider, 2 error stages,
// one sum stage per anchor and the output register.
// All anchors run in parallel lanes.
// When out_ch stalls the whole pipeline holds and in_ch.ready drops, so no
// item is lost or repeated. Reset clears all valid bits and the measured
// voltages; the block accepts a position in the first cycle after reset.

module dipole_localization_cost_core import dlc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  dlc_in_if.sink       in_ch,
  dlc_out_if.source    out_ch,
  dlc_cfg_if.sink      cfg_ch
);

  logic              adv;
  logic [VOLT_W-1:0] meas_r [4];

  logic              out_valid_r, out_sat_r;
  logic [COST_W-1:0] out_cost_r;

  logic              s0_v_r, s1_v_r, s2_v_r;
  logic [ABS_W-1:0]  ex_r [ANCHOR_CNT], ey_r [ANCHOR_CNT], ez_r [ANCHOR_CNT];
  logic [SQR_W-1:0]  xx_r [ANCHOR_CNT], yy_r [ANCHOR_CNT], zz_r [ANCHOR_CNT];
  logic [D2_W-1:0]   d2_r [ANCHOR_CNT];
  logic [NUM_W-1:0]  num_r [ANCHOR_CNT];
  logic              zero_r [ANCHOR_CNT];

  ctl_t              g_ctl [ANCHOR_CNT];
  logic [D2_W-1:0]   g_d2  [ANCHOR_CNT];
  logic [Q_W-1:0]    g_q   [ANCHOR_CNT];
  logic [S_W-1:0]    g_s   [ANCHOR_CNT];

  ctl_t              m1_ctl_r [ANCHOR_CNT], m2_ctl_r [ANCHOR_CNT], m3_ctl_r [ANCHOR_CNT];
  logic [FQ_W-1:0]   fq_r   [ANCHOR_CNT];
  logic [DSL_W-1:0]  dsl_r  [ANCHOR_CNT];
  logic [DSH_W-1:0]  dsh_r  [ANCHOR_CNT];
  logic [GP_W-1:0]   gpl_r  [ANCHOR_CNT], gph_r [ANCHOR_CNT];
  logic [DEN_W-1:0]  den2_r [ANCHOR_CNT], den3_r [ANCHOR_CNT];
  logic [NUMV_W-1:0] numv_r [ANCHOR_CNT];

  ctl_t              v_ctl [ANCHOR_CNT];
  logic [V_W-1:0]    v_val [ANCHOR_CNT];

  ctl_t              p1_ctl_r [ANCHOR_CNT], p2_ctl_r [ANCHOR_CNT];
  logic [VOLT_W-1:0] e_r  [ANCHOR_CNT];
  logic [COST_W-1:0] sq_r [ANCHOR_CNT];
  logic              p2_bad [ANCHOR_CNT];

  ctl_t              acc_ctl;
  logic [COST_W-1:0] acc_sum;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r <= '{default: '0};
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_MEAS_V0: meas_r[0] <= cfg_ch.data;
        REG_MEAS_V1: meas_r[1] <= cfg_ch.data;
        REG_MEAS_V2: meas_r[2] <= cfg_ch.data;
        REG_MEAS_V3: meas_r[3] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_ch.valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  for (genvar k = 0; k < ANCHOR_CNT; k++) begin : g_lane
    localparam int A = k % 4;
    logic [D2_W-1:0]   d2_nxt;
    logic [NUM_W-1:0]  two, lat, num_nxt;
    logic [V_W-1:0]    mv, e_full;

    assign d2_nxt  = D2_W'(xx_r[k]) + D2_W'(yy_r[k]) + D2_W'(zz_r[k]);
    assign two     = {zz_r[k], 1'b0};
    assign lat     = NUM_W'(xx_r[k]) + NUM_W'(yy_r[k]);
    assign num_nxt = (two >= lat) ? two - lat : lat - two;
    assign mv      = V_W'(meas_r[A]);
    assign e_full  = (v_val[k] >= mv) ? v_val[k] - mv : mv - v_val[k];

    always_ff @(posedge clk) begin
      if (adv) begin
        ex_r[k]   <= abs_diff(ANCHOR_XYZ[A*3],   in_ch.pos_x);
        ey_r[k]   <= abs_diff(ANCHOR_XYZ[A*3+1], in_ch.pos_y);
        ez_r[k]   <= abs_diff(ANCHOR_XYZ[A*3+2], in_ch.pos_z);
        xx_r[k]   <= SQR_W'(ex_r[k]) * SQR_W'(ex_r[k]);
        yy_r[k]   <= SQR_W'(ey_r[k]) * SQR_W'(ey_r[k]);
        zz_r[k]   <= SQR_W'(ez_r[k]) * SQR_W'(ez_r[k]);
        d2_r[k]   <= d2_nxt;
        num_r[k]  <= num_nxt;
        zero_r[k] <= d2_nxt == '0;
      end
    end

    dlc_geom u_geom (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .ctl_i ('{valid: s2_v_r, bad: zero_r[k]}),
      .d2_i  (d2_r[k]),
      .num_i (num_r[k]),
      .ctl_o (g_ctl[k]),
      .d2_o  (g_d2[k]),
      .q_o   (g_q[k]),
      .s_o   (g_s[k])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m1_ctl_r[k] <= '0;
        m2_ctl_r[k] <= '0;
        m3_ctl_r[k] <= '0;
        p1_ctl_r[k] <= '0;
        p2_ctl_r[k] <= '0;
      end else if (adv) begin
        m1_ctl_r[k] <= g_ctl[k];
        m2_ctl_r[k] <= m1_ctl_r[k];
        m3_ctl_r[k] <= m2_ctl_r[k];
        p1_ctl_r[k] <= '{valid: v_ctl[k].valid,
                         bad: v_ctl[k].bad | (e_full[V_W-1:VOLT_W] != '0)};
        p2_ctl_r[k] <= p1_ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fq_r[k]   <= FQ_W'(ANCHOR_FREQ[A]) * FQ_W'(g_q[k]);
        dsl_r[k]  <= DSL_W'(g_d2[k][D2_SPLIT-1:0]) * DSL_W'(g_s[k]);
        dsh_r[k]  <= DSH_W'(g_d2[k][D2_W-1:D2_SPLIT]) * DSH_W'(g_s[k]);
        gpl_r[k]  <= GP_W'(DIPOLE_GAIN) * GP_W'(fq_r[k][FQ_SPLIT-1:0]);
        gph_r[k]  <= GP_W'(DIPOLE_GAIN) * GP_W'(fq_r[k][FQ_W-1:FQ_SPLIT]);
        den2_r[k] <= DEN_W'(dsl_r[k]) + (DEN_W'(dsh_r[k]) << D2_SPLIT);
        numv_r[k] <= NUMV_W'(gpl_r[k]) + (NUMV_W'(gph_r[k]) << FQ_SPLIT);
        den3_r[k] <= den2_r[k];
        e_r[k]    <= e_full[VOLT_W-1:0];
        sq_r[k]   <= COST_W'(e_r[k]) * COST_W'(e_r[k]);
      end
    end

    dlc_vdiv u_vdiv (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .ctl_i (m3_ctl_r[k]),
      .num_i (numv_r[k]),
      .den_i (den3_r[k]),
      .ctl_o (v_ctl[k]),
      .v_o   (v_val[k])
    );

    assign p2_bad[k] = p2_ctl_r[k].bad;
  end

  dlc_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (p2_ctl_r[0].valid),
    .bad_i   (p2_bad),
    .sq_i    (sq_r),
    .ctl_o   (acc_ctl),
    .sum_o   (acc_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= acc_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cost_r <= acc_ctl.bad ? '1 : acc_sum;
      out_sat_r  <= acc_ctl.bad;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cost_value = out_cost_r;
  assign out_ch.saturated  = out_sat_r;

endmodule

>>> rtl/dlc_checker.sv
`timescale 1ns / 1ps
// port-level checks for the dipole localization cost core, bound to the top level
// depends on dlc_pkg and dipole_localization_cost_core

module dlc_checker import dlc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [COST_W-1:0] out_cost,
  input logic              out_sat
);

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat |-> out_cost == '1)
    else $error("saturated result without full-scale cost");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cost) && $stable(out_sat))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result before any transfer");

endmodule

bind dipole_localization_cost_core dlc_checker u_dlc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_cost  (out_ch.cost_value),
  .out_sat   (out_ch.saturated)
);
